### hdl/iffd_pkg.sv
// Package for the IFF chunk deframer: parse phases, constants, result codes
// and the per-byte result bundle passed from the parser to the result queue.
// No dependencies.
`timescale 1ns / 1ps

package iffd_pkg;

  // Default width of the byte position counter
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed header words, first character in the top byte
  localparam logic [31:0] MAGIC_FORM = 32'h464F_524D;
  localparam logic [31:0] TYPE_IFRS  = 32'h4946_5253;

  // File layout
  localparam logic [31:0] FIRST_CHUNK  = 32'd12;
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  // Result kinds
  localparam logic [1:0] KIND_CHUNK = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes
  localparam logic [2:0] ERR_MAGIC       = 3'd0;
  localparam logic [2:0] ERR_SIZE        = 3'd1;
  localparam logic [2:0] ERR_FORM_TYPE   = 3'd2;
  localparam logic [2:0] ERR_HEADER_CUT  = 3'd3;
  localparam logic [2:0] ERR_CHUNK_CUT   = 3'd4;
  localparam logic [2:0] ERR_OVERRUN     = 3'd5;
  localparam logic [2:0] ERR_NONE        = 3'd0;

  // Parse phases
  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_SIZE    = 3'd1,
    PH_FTYPE   = 3'd2,
    PH_SKIP    = 3'd3,
    PH_CTYPE   = 3'd4,
    PH_CLEN    = 3'd5,
    PH_SWALLOW = 3'd6
  } phase_t;

  // Everything one byte produces: an optional chunk record, then an
  // optional closing result (done or error)
  typedef struct packed {
    logic        rec;
    logic        tail;
    logic [1:0]  tail_kind;
    logic [2:0]  tail_code;
    logic [31:0] ctype;
    logic [31:0] coffset;
    logic [31:0] clength;
  } step_t;

endpackage

### hdl/iff_chunk_deframer.sv
// IFF FORM/IFRS chunk deframer, top level: joins the byte parser and the
// result queue. Depends on iffd_pkg, iffd_parser and iffd_result_queue.
//
// Usage:
// - Write the file length on the configuration channel (cfg_valid, cfg_ready,
//   file_length) while the block is idle; cfg_ready is always high.
// - Stream the file one byte a beat on data_byte (in_valid / in_stall).
//   One byte is taken per cycle while in_stall is low; the parser does all
//   its work for a byte in the cycle it is taken.
// - Results leave on kind, error_code, chunk_type, chunk_offset,
//   chunk_length and last (out_valid / out_stall). A result is registered
//   into the queue when its byte is taken and offered from there; a byte
//   that gives a chunk record and a closing result sends them on two
//   successive beats, last marking the second.
// - A two-entry result queue decouples the sides: bytes keep flowing while
//   results wait, and in_stall rises only when two bytes' worth of results
//   are held. Sustained rate is one byte per cycle while the receiver keeps
//   up; the queue drains one beat per cycle while out_stall is low.
// - After the last byte of a file the parser restarts at position zero.
// - Synchronous reset clears the parser, the queue and the file length.
`timescale 1ns / 1ps

module iff_chunk_deframer #(
  parameter int OFFSET_BITS = iffd_pkg::OFFSET_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] file_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [2:0]  error_code,
  output logic [31:0] chunk_type,
  output logic [31:0] chunk_offset,
  output logic [31:0] chunk_length,
  output logic        last
);
  import iffd_pkg::*;

  logic  accept;
  logic  cfg_wr;
  logic  push;
  logic  full;
  step_t step;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = full;
  assign accept    = in_valid && !in_stall;

  iffd_parser #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_data  (file_length),
    .accept    (accept),
    .data_byte (data_byte),
    .push      (push),
    .step      (step)
  );

  iffd_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .step         (step),
    .full         (full),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .error_code   (error_code),
    .chunk_type   (chunk_type),
    .chunk_offset (chunk_offset),
    .chunk_length (chunk_length),
    .last         (last)
  );

endmodule

### hdl/iffd_parser.sv
// Byte-wise parse state machine of the IFF chunk deframer: header checks,
// chunk header capture, skip tracking and end-of-file handling.
// Depends on iffd_pkg.
`timescale 1ns / 1ps

module iffd_parser #(
  parameter int OFFSET_BITS = iffd_pkg::OFFSET_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr,
  input  logic [31:0]   cfg_data,
  input  logic          accept,
  input  logic [7:0]    data_byte,
  output logic          push,
  output iffd_pkg::step_t step
);
  import iffd_pkg::*;

  // Compare width: holds position + 1 and a chunk end of up to 34 bits
  localparam int CW = (OFFSET_BITS + 1 > 34) ? OFFSET_BITS + 1 : 34;

  logic [31:0]            file_length;
  logic [OFFSET_BITS-1:0] byte_position;
  phase_t                 phase;
  logic [31:0]            field_shift;
  logic [31:0]            held_type;
  logic [31:0]            chunk_start;
  logic [31:0]            next_chunk_start;

  logic [OFFSET_BITS-1:0] byte_position_next;
  phase_t                 phase_next;
  logic [31:0]            field_shift_next;
  logic [31:0]            held_type_next;
  logic [31:0]            chunk_start_next;
  logic [31:0]            next_chunk_start_next;

  logic [CW-1:0] pos_inc;
  logic [CW-1:0] len_ext;
  logic [CW-1:0] chunk_end;
  logic          at_end;
  logic          size_bad;
  logic [31:0]   len_minus_hdr;
  logic [1:0]    field_idx;

  // Shared arithmetic
  assign field_shift_next = {field_shift[23:0], data_byte};
  assign pos_inc   = CW'(byte_position) + CW'(1);
  assign len_ext   = CW'(file_length);
  assign at_end    = (pos_inc >= len_ext);
  assign len_minus_hdr = file_length - HEADER_BYTES;
  assign size_bad  = (file_length < HEADER_BYTES) || (field_shift_next != len_minus_hdr);
  assign chunk_end = CW'(chunk_start) + CW'(HEADER_BYTES) + CW'(field_shift_next)
                     + CW'(field_shift_next[0]);
  assign field_idx = byte_position[1:0] - chunk_start[1:0];

  // Next state and results for the byte on the input
  always_comb begin
    phase_next            = phase;
    held_type_next        = held_type;
    chunk_start_next      = chunk_start;
    next_chunk_start_next = next_chunk_start;
    step                  = '0;

    case (phase)
      PH_MAGIC, PH_SIZE, PH_FTYPE: begin
        if (byte_position[1:0] == 2'b11) begin
          if (phase == PH_MAGIC) begin
            if (field_shift_next != MAGIC_FORM) begin
              step.tail      = 1'b1;
              step.tail_kind = KIND_ERROR;
              step.tail_code = ERR_MAGIC;
              phase_next     = PH_SWALLOW;
            end else begin
              phase_next = PH_SIZE;
            end
          end else if (phase == PH_SIZE) begin
            if (size_bad) begin
              step.tail      = 1'b1;
              step.tail_kind = KIND_ERROR;
              step.tail_code = ERR_SIZE;
              phase_next     = PH_SWALLOW;
            end else begin
              phase_next = PH_FTYPE;
            end
          end else begin
            if (field_shift_next != TYPE_IFRS) begin
              step.tail      = 1'b1;
              step.tail_kind = KIND_ERROR;
              step.tail_code = ERR_FORM_TYPE;
              phase_next     = PH_SWALLOW;
            end else begin
              next_chunk_start_next = FIRST_CHUNK;
              chunk_start_next      = FIRST_CHUNK;
              phase_next            = at_end ? PH_SKIP : PH_CTYPE;
            end
          end
        end
      end
      PH_SKIP: begin
        if (!at_end && pos_inc == CW'(next_chunk_start)) begin
          chunk_start_next = next_chunk_start;
          phase_next       = PH_CTYPE;
        end
      end
      PH_CTYPE: begin
        if (field_idx == 2'b11) begin
          held_type_next = field_shift_next;
          phase_next     = PH_CLEN;
        end
      end
      PH_CLEN: begin
        if (field_idx == 2'b11) begin
          step.rec     = 1'b1;
          step.ctype   = held_type;
          step.coffset = chunk_start;
          step.clength = field_shift_next;
          if (chunk_end > len_ext) begin
            step.tail      = 1'b1;
            step.tail_kind = KIND_ERROR;
            step.tail_code = ERR_OVERRUN;
            phase_next     = PH_SWALLOW;
          end else begin
            next_chunk_start_next = chunk_end[31:0];
            if (!at_end && pos_inc == chunk_end) begin
              chunk_start_next = chunk_end[31:0];
              phase_next       = PH_CTYPE;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
      end
      default: begin
        phase_next = PH_SWALLOW;
      end
    endcase

    // Last byte of the file: close out and restart for the next file
    byte_position_next = pos_inc[OFFSET_BITS-1:0];
    if (at_end) begin
      if (!step.tail) begin
        if (phase_next inside {PH_MAGIC, PH_SIZE, PH_FTYPE}) begin
          step.tail      = 1'b1;
          step.tail_kind = KIND_ERROR;
          step.tail_code = ERR_HEADER_CUT;
        end else if (phase_next inside {PH_CTYPE, PH_CLEN}) begin
          step.tail      = 1'b1;
          step.tail_kind = KIND_ERROR;
          step.tail_code = ERR_CHUNK_CUT;
        end else if (phase_next == PH_SKIP) begin
          step.tail      = 1'b1;
          step.tail_kind = KIND_DONE;
          step.tail_code = ERR_NONE;
        end
      end
      byte_position_next    = '0;
      phase_next            = PH_MAGIC;
      held_type_next        = '0;
      chunk_start_next      = '0;
      next_chunk_start_next = FIRST_CHUNK;
    end
  end

  assign push = accept && (step.rec || step.tail);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      file_length      <= '0;
      byte_position    <= '0;
      phase            <= PH_MAGIC;
      field_shift      <= '0;
      held_type        <= '0;
      chunk_start      <= '0;
      next_chunk_start <= FIRST_CHUNK;
    end else begin
      if (cfg_wr) begin
        file_length <= cfg_data;
      end
      if (accept) begin
        byte_position    <= byte_position_next;
        phase            <= phase_next;
        field_shift      <= at_end ? 32'd0 : field_shift_next;
        held_type        <= held_type_next;
        chunk_start      <= chunk_start_next;
        next_chunk_start <= next_chunk_start_next;
      end
    end
  end

endmodule

### hdl/iffd_result_queue.sv
// Two-entry result queue of the IFF chunk deframer. Each entry holds what
// one byte produced and is unpacked into one or two output beats.
// Depends on iffd_pkg.
`timescale 1ns / 1ps

module iffd_result_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  iffd_pkg::step_t step,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [1:0]      kind,
  output logic [2:0]      error_code,
  output logic [31:0]     chunk_type,
  output logic [31:0]     chunk_offset,
  output logic [31:0]     chunk_length,
  output logic            last
);
  import iffd_pkg::*;

  step_t       entries [2];
  logic        rd_ptr;
  logic        wr_ptr;
  logic [1:0]  count;
  step_t       head;
  logic        pop_beat;
  logic        pop_entry;

  assign head      = entries[rd_ptr];
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign pop_beat  = out_valid && !out_stall;
  // An entry with a record and a closing result needs two beats
  assign pop_entry = pop_beat && !(head.rec && head.tail);

  // Output beat from the head entry: record first, then the closing result
  always_comb begin
    if (head.rec) begin
      kind         = KIND_CHUNK;
      error_code   = ERR_NONE;
      chunk_type   = head.ctype;
      chunk_offset = head.coffset;
      chunk_length = head.clength;
      last         = !head.tail;
    end else begin
      kind         = head.tail_kind;
      error_code   = head.tail_code;
      chunk_type   = '0;
      chunk_offset = '0;
      chunk_length = '0;
      last         = 1'b1;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= step;
    end
    if (pop_beat && !pop_entry) begin
      entries[rd_ptr].rec <= 1'b0;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop_entry) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop_entry) begin
        count <= count + 2'd1;
      end else if (!push && pop_entry) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
